/* hdl/vlqc_pkg.sv */
// Shared constants, types and helpers for the 7-bit big-endian varint codec.
`default_nettype none
package vlqc_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGIT_W  = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned MAX_DIGITS = 5;
    localparam int unsigned WORK_W   = DIGIT_W * MAX_DIGITS;

    localparam logic [1:0] CMD_ENCODE = 2'd0;
    localparam logic [1:0] CMD_SIZE   = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DIGITS);

    typedef logic [WORK_W-1:0]  t_work;
    typedef logic [DIGIT_W-1:0] t_digit;

    // number of 7-bit digits needed for a value, at least one
    function automatic logic [COUNT_W-1:0] digit_count(input logic [VALUE_W-1:0] v);
        logic [COUNT_W-1:0] n;
        begin
            if (v[31:28] != '0) begin
                n = 3'd5;
            end else if (v[27:21] != '0) begin
                n = 3'd4;
            end else if (v[20:14] != '0) begin
                n = 3'd3;
            end else if (v[13:7] != '0) begin
                n = 3'd2;
            end else begin
                n = 3'd1;
            end
            return n;
        end
    endfunction

    // place the leading digit of a value at the top of the work word
    function automatic t_work align_work(input logic [VALUE_W-1:0] v,
                                         input logic [COUNT_W-1:0] n);
        t_work w;
        begin
            case (n)
                3'd5:    w = {3'b000, v};
                3'd4:    w = {v[27:0], 7'd0};
                3'd3:    w = {v[20:0], 14'd0};
                3'd2:    w = {v[13:0], 21'd0};
                default: w = {v[6:0], 28'd0};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/vlqc_stream_if.sv */
// Valid/ready channels for command items and result items.
`default_nettype none
interface vlqc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] value;
    logic [7:0]  in_byte;

    modport source (output valid, output command, output value, output in_byte, input ready);
    modport sink   (input valid, input command, input value, input in_byte, output ready);
endinterface

interface vlqc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [31:0] decoded_value;
    logic [2:0]  byte_count;
    logic        terminated;
    logic        last;

    modport source (output valid, output out_byte, output decoded_value, output byte_count,
                    output terminated, output last, input ready);
    modport sink   (input valid, input out_byte, input decoded_value, input byte_count,
                    input terminated, input last, output ready);
endinterface
`default_nettype wire

/* hdl/vlqc_digit_unit.sv */
// Shared 7-bit digit shifter: takes the top digit and shifts a new digit in at the bottom.
`default_nettype none
module vlqc_digit_unit
    import vlqc_pkg::*;
(
    input  wire t_work  i_operand,
    input  wire t_digit i_digit,
    output t_work       o_shifted,
    output t_digit      o_top
);

    assign o_top     = i_operand[WORK_W-1 -: DIGIT_W];
    assign o_shifted = {i_operand[WORK_W-DIGIT_W-1:0], i_digit};

endmodule
`default_nettype wire

/* hdl/varint_7bit_be_codec_core.sv */
// Top level of the 7-bit big-endian varint codec.
// Size query and decode: result registered in the cycle after the completing item; one item
//   per cycle while output is free. Encode of an n-digit value: bytes leave one per cycle
//   while output is free, through the shared digit shifter, encode state and result register;
//   the next item is taken after the last byte. Output stalls hold the sequencer and the input.
// Reset (synchronous, active low) clears the decode accumulator, byte count and all valids.
`default_nettype none
module varint_7bit_be_codec_core
    import vlqc_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    vlqc_cmd_if.sink        i_cmd,
    vlqc_res_if.source      o_res
);

    typedef enum logic {
        ST_IDLE,
        ST_ENCODE
    } t_state;

    t_state               r_state,   n_state;
    t_work                r_work,    n_work;
    logic [COUNT_W-1:0]   r_rem,     n_rem;
    logic [VALUE_W-1:0]   r_acc,     n_acc;
    logic [COUNT_W-1:0]   r_taken,   n_taken;
    logic                 r_ovalid,  n_ovalid;
    logic [BYTE_W-1:0]    r_obyte,   n_obyte;
    logic [VALUE_W-1:0]   r_oval,    n_oval;
    logic [COUNT_W-1:0]   r_ocnt,    n_ocnt;
    logic                 r_oterm,   n_oterm;
    logic                 r_olast,   n_olast;

    t_work                unit_operand;
    t_digit               unit_digit;
    t_work                unit_shifted;
    t_digit               unit_top;
    logic                 out_free;
    logic                 accept;
    logic [COUNT_W-1:0]   in_count;
    logic [COUNT_W-1:0]   taken_inc;

    vlqc_digit_unit u_digit (
        .i_operand (unit_operand),
        .i_digit   (unit_digit),
        .o_shifted (unit_shifted),
        .o_top     (unit_top)
    );

    assign out_free    = !r_ovalid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign in_count    = digit_count(i_cmd.value);
    assign taken_inc   = r_taken + 3'd1;

    always_comb begin
        if (r_state == ST_ENCODE) begin
            unit_operand = r_work;
            unit_digit   = '0;
        end else begin
            unit_operand = {{(WORK_W-VALUE_W){1'b0}}, r_acc};
            unit_digit   = i_cmd.in_byte[DIGIT_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_work   = r_work;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_taken  = r_taken;
        n_ovalid = r_ovalid && !o_res.ready;
        n_obyte  = r_obyte;
        n_oval   = r_oval;
        n_ocnt   = r_ocnt;
        n_oterm  = r_oterm;
        n_olast  = r_olast;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        CMD_ENCODE: begin
                            n_work  = align_work(i_cmd.value, in_count);
                            n_rem   = in_count;
                            n_state = ST_ENCODE;
                        end
                        CMD_SIZE: begin
                            n_ovalid = 1'b1;
                            n_obyte  = '0;
                            n_oval   = '0;
                            n_ocnt   = in_count;
                            n_oterm  = 1'b0;
                            n_olast  = 1'b1;
                        end
                        CMD_DECODE: begin
                            if (i_cmd.in_byte[BYTE_W-1] || taken_inc == COUNT_MAX) begin
                                n_ovalid = 1'b1;
                                n_obyte  = '0;
                                n_oval   = unit_shifted[VALUE_W-1:0];
                                n_ocnt   = taken_inc;
                                n_oterm  = i_cmd.in_byte[BYTE_W-1];
                                n_olast  = 1'b1;
                                n_acc    = '0;
                                n_taken  = '0;
                            end else begin
                                n_acc   = unit_shifted[VALUE_W-1:0];
                                n_taken = taken_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENCODE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = {(r_rem == 3'd1), unit_top};
                    n_oval   = '0;
                    n_ocnt   = '0;
                    n_oterm  = 1'b0;
                    n_olast  = (r_rem == 3'd1);
                    n_work   = unit_shifted;
                    n_rem    = r_rem - 3'd1;
                    if (r_rem == 3'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acc    <= '0;
            r_taken  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_taken  <= n_taken;
            r_ovalid <= n_ovalid;
        end
        r_work  <= n_work;
        r_rem   <= n_rem;
        r_obyte <= n_obyte;
        r_oval  <= n_oval;
        r_ocnt  <= n_ocnt;
        r_oterm <= n_oterm;
        r_olast <= n_olast;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.out_byte      = r_obyte;
    assign o_res.decoded_value = r_oval;
    assign o_res.byte_count    = r_ocnt;
    assign o_res.terminated    = r_oterm;
    assign o_res.last          = r_olast;

endmodule
`default_nettype wire
